@@ rtl/core/ipv4rx_pkg.sv @@
// Shared types, register indexes and constants for the IPv4 receive header checker.
`timescale 1ns / 1ps

package ipv4rx_pkg;

  // Number of local address registers that are built.
  localparam int unsigned NumLocalAddrsDefault = 4;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegLocalAddr0   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegAddrCount    = 4'd4;
  localparam logic [CfgIdxW-1:0] RegPromiscuous  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegAnyProtocol  = 4'd6;
  localparam logic [CfgIdxW-1:0] RegWantedProto  = 4'd7;

  // Header layout and limits.
  localparam logic [15:0] MinHeaderBytes = 16'd20;
  localparam logic [15:0] CountMax       = 16'hFFFF;
  localparam logic [15:0] PosIhl         = 16'd0;
  localparam logic [15:0] PosLenHigh     = 16'd2;
  localparam logic [15:0] PosLenLow      = 16'd3;
  localparam logic [15:0] PosProto       = 16'd9;
  localparam logic [15:0] PosDstFirst    = 16'd16;
  localparam logic [15:0] PosDstLast     = 16'd19;
  localparam logic [15:0] SumGood        = 16'hFFFF;
  localparam logic [7:0]  IhlMask        = 8'h0F;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTruncHdr = 2'd1,
    StTruncPkt = 2'd2,
    StCsumErr  = 2'd3
  } status_e;

  // Per-packet state after the current byte is folded in.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] sum_acc;
    logic [3:0]  ihl_field;
    logic [15:0] length_field;
    logic [7:0]  proto_field;
    logic [31:0] dst_field;
  } pkt_state_t;

  // Filter settings from the configuration registers.
  typedef struct packed {
    logic [2:0] addr_count;
    logic       promiscuous;
    logic       any_protocol;
    logic [7:0] wanted_protocol;
  } filter_cfg_t;

  // One result transaction.
  typedef struct packed {
    status_e     status;
    logic [5:0]  header_length;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic        dst_local;
    logic [1:0]  match_index;
    logic        deliver;
  } result_t;

  // Ones-complement 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

@@ rtl/core/ipv4rx_intf.sv @@
// Channel interfaces: packet bytes in, header check results out.
`timescale 1ns / 1ps

interface ipv4rx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4rx_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  header_length;
  logic [15:0] total_length;
  logic [7:0]  protocol_number;
  logic        dst_local;
  logic [1:0]  match_index;
  logic        deliver;

  modport source (
    output valid, output status, output header_length, output total_length,
    output protocol_number, output dst_local, output match_index, output deliver,
    input ready
  );
  modport sink (
    input valid, input status, input header_length, input total_length,
    input protocol_number, input dst_local, input match_index, input deliver,
    output ready
  );
endinterface

@@ rtl/core/ipv4rx_hdr_track.sv @@
// Per-packet byte counter, field capture and running header checksum.
`timescale 1ns / 1ps

module ipv4rx_hdr_track import ipv4rx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output pkt_state_t upd_o
);

  pkt_state_t  state_q, state_d;
  logic [7:0]  hold_q, hold_d;
  pkt_state_t  upd;
  logic [15:0] pos;
  logic [15:0] hlen;
  logic        counted;

  // Fold the current byte into the packet state.
  always_comb begin
    upd     = state_q;
    hold_d  = hold_q;
    pos     = state_q.byte_count;
    counted = (pos != CountMax);
    hlen    = 16'd0;
    if (counted) begin
      if (pos == PosIhl) begin
        upd.ihl_field = data_byte_i[3:0] & IhlMask[3:0];
      end else if (pos == PosLenHigh) begin
        upd.length_field = {data_byte_i, state_q.length_field[7:0]};
      end else if (pos == PosLenLow) begin
        upd.length_field = {state_q.length_field[15:8], data_byte_i};
      end else if (pos == PosProto) begin
        upd.proto_field = data_byte_i;
      end else if (pos >= PosDstFirst && pos <= PosDstLast) begin
        upd.dst_field = {state_q.dst_field[23:0], data_byte_i};
      end
      hlen = {10'd0, upd.ihl_field, 2'b00};
      // Header bytes pair up into big-endian 16-bit words.
      if (pos < hlen) begin
        if (!pos[0]) begin
          hold_d = data_byte_i;
        end else begin
          upd.sum_acc = oc_add(state_q.sum_acc, {hold_q, data_byte_i});
        end
      end
      upd.byte_count = pos + 16'd1;
    end
  end

  // The last byte of a packet clears everything for the next one.
  always_comb begin
    state_d = state_q;
    if (adv_i) begin
      state_d = last_byte_i ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      hold_q  <= '0;
    end else begin
      state_q <= state_d;
      if (adv_i) begin
        hold_q <= last_byte_i ? 8'd0 : hold_d;
      end
    end
  end

  assign upd_o = upd;

endmodule

@@ rtl/core/ipv4rx_classify.sv @@
// Status, local address match and deliver decision for a finished packet.
`timescale 1ns / 1ps

module ipv4rx_classify import ipv4rx_pkg::*; #(
  parameter int unsigned NUM_LOCAL_ADDRS = NumLocalAddrsDefault
) (
  input  pkt_state_t  pkt_i,
  input  filter_cfg_t cfg_i,
  input  logic [31:0] local_addr_i [NUM_LOCAL_ADDRS],
  output result_t     res_o
);

  logic [5:0] hlen;
  status_e    status;
  logic       found;
  logic [1:0] idx;
  logic       proto_ok;

  assign hlen = {pkt_i.ihl_field, 2'b00};

  // Status in priority order.
  always_comb begin
    if (pkt_i.byte_count < MinHeaderBytes) begin
      status = StTruncHdr;
    end else if (pkt_i.byte_count < pkt_i.length_field ||
                 pkt_i.length_field < {10'd0, hlen}) begin
      status = StTruncPkt;
    end else if (pkt_i.sum_acc != SumGood) begin
      status = StCsumErr;
    end else begin
      status = StOk;
    end
  end

  // Lowest enabled local address that equals the destination.
  always_comb begin
    found = 1'b0;
    idx   = 2'd0;
    for (int i = 0; i < NUM_LOCAL_ADDRS; i++) begin
      if (!found && (cfg_i.addr_count > 3'(i)) && (local_addr_i[i] == pkt_i.dst_field)) begin
        found = 1'b1;
        idx   = 2'(i);
      end
    end
  end

  assign proto_ok = cfg_i.any_protocol || (cfg_i.wanted_protocol == pkt_i.proto_field);

  always_comb begin
    res_o.status          = status;
    res_o.header_length   = hlen;
    res_o.total_length    = pkt_i.length_field;
    res_o.protocol_number = pkt_i.proto_field;
    res_o.dst_local       = found;
    res_o.match_index     = idx;
    res_o.deliver         = (status == StOk) && (cfg_i.promiscuous || found) && proto_ok;
  end

endmodule

@@ rtl/core/ipv4_receive_header_checker.sv @@
// Top level of the IPv4 receive header checker.
//
// Usage: packet bytes arrive on in_ch, header first, one byte per transaction,
// with last_byte set on the final byte. Every byte is registered, then folded
// into a byte count, the captured IHL, total length, protocol and destination
// fields and a ones-complement header sum. The final byte of a packet yields
// one transaction on out_ch with the status, the captured fields, the local
// address match and the deliver flag; other bytes yield nothing.
// The final byte is first captured in the input register; its result is then
// loaded into the result register, which drives out_ch.
// Throughput: one byte per cycle unless a final byte stalls as below.
// The result register lets bytes keep flowing while a result waits; only a
// final byte that finds the result register still full and unread stalls,
// and in_ch.ready then drops until out_ch takes its result.
// Configuration is to be written through cfg_we_i / cfg_index_i / cfg_data_i
// only while no packet is in flight; the block does not enforce this. Writes
// to unknown indexes are ignored. Reset clears the packet state, the
// configuration (any_protocol comes up as 1) and empties both channels.
`timescale 1ns / 1ps

module ipv4_receive_header_checker import ipv4rx_pkg::*; #(
  parameter int unsigned NUM_LOCAL_ADDRS = NumLocalAddrsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ipv4rx_byte_if.sink         in_ch,
  ipv4rx_result_if.source     out_ch
);

  logic [31:0] local_addr_q [NUM_LOCAL_ADDRS];
  filter_cfg_t cfg_q;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        stall;
  logic        adv;

  pkt_state_t  pkt_upd;
  result_t     res;
  logic        out_vld_q;
  result_t     out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LOCAL_ADDRS; i++) begin
        local_addr_q[i] <= '0;
      end
      cfg_q.addr_count      <= '0;
      cfg_q.promiscuous     <= 1'b0;
      cfg_q.any_protocol    <= 1'b1;
      cfg_q.wanted_protocol <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_LOCAL_ADDRS; i++) begin
        if (cfg_index_i == RegLocalAddr0 + CfgIdxW'(i)) begin
          local_addr_q[i] <= cfg_data_i;
        end
      end
      if (cfg_index_i == RegAddrCount) begin
        cfg_q.addr_count <= cfg_data_i[2:0];
      end
      if (cfg_index_i == RegPromiscuous) begin
        cfg_q.promiscuous <= cfg_data_i[0];
      end
      if (cfg_index_i == RegAnyProtocol) begin
        cfg_q.any_protocol <= cfg_data_i[0];
      end
      if (cfg_index_i == RegWantedProto) begin
        cfg_q.wanted_protocol <= cfg_data_i[7:0];
      end
    end
  end

  // A final byte waits when the result register is full and not being read.
  assign stall       = in_vld_q && in_last_q && out_vld_q && !out_ch.ready;
  assign adv         = in_vld_q && !stall;
  assign in_ch.ready = !stall;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.data_byte;
      in_last_q <= in_ch.last_byte;
    end
  end

  ipv4rx_hdr_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .upd_o       (pkt_upd)
  );

  ipv4rx_classify #(
    .NUM_LOCAL_ADDRS (NUM_LOCAL_ADDRS)
  ) u_classify (
    .pkt_i        (pkt_upd),
    .cfg_i        (cfg_q),
    .local_addr_i (local_addr_q),
    .res_o        (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_q <= res;
    end
  end

  assign out_ch.valid           = out_vld_q;
  assign out_ch.status          = out_q.status;
  assign out_ch.header_length   = out_q.header_length;
  assign out_ch.total_length    = out_q.total_length;
  assign out_ch.protocol_number = out_q.protocol_number;
  assign out_ch.dst_local       = out_q.dst_local;
  assign out_ch.match_index     = out_q.match_index;
  assign out_ch.deliver         = out_q.deliver;

endmodule
